/* rtl/pil_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pil_pkg;

  localparam int HIST_DEPTH = 8;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 3;
  localparam int WINDOW_W   = 17;
  localparam int EDGE_W     = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(300);

  localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_RISING  = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_FALLING = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // one input word, lowest field last
  typedef struct packed {
    logic [SLOT_W-1:0] read_slot;
    logic [TIME_W-1:0] now_seconds;
    logic              sensor_level;
  } item_t;

  // one result word, lowest field last
  typedef struct packed {
    logic [TIME_W-1:0] slot_end;
    logic [TIME_W-1:0] slot_start;
    logic              merged;
    logic [EDGE_W-1:0] edge_seen;
    logic              active;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

endpackage

`default_nettype wire

/* rtl/pil_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module pil_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          upd_en,
  input  wire pil_pkg::item_t                item,
  input  wire logic [pil_pkg::WINDOW_W-1:0]  merge_window,
  output pil_pkg::res_t                      res
);

  logic                        last_level_r;
  logic                        last_level_nxt;
  logic [pil_pkg::TIME_W-1:0]  start_r   [pil_pkg::HIST_DEPTH];
  logic [pil_pkg::TIME_W-1:0]  end_r     [pil_pkg::HIST_DEPTH];
  logic [pil_pkg::TIME_W-1:0]  start_nxt [pil_pkg::HIST_DEPTH];
  logic [pil_pkg::TIME_W-1:0]  end_nxt   [pil_pkg::HIST_DEPTH];

  logic                        rise;
  logic                        fall;
  logic [pil_pkg::TIME_W:0]    gap;
  logic                        in_window;

  assign rise = item.sensor_level & ~last_level_r;
  assign fall = ~item.sensor_level & last_level_r;

  // signed gap: a negative value always counts as inside the window
  assign gap       = {1'b0, item.now_seconds} - {1'b0, end_r[0]};
  assign in_window = gap[pil_pkg::TIME_W] ||
                     (gap[pil_pkg::TIME_W-1:0] <=
                      pil_pkg::TIME_W'(merge_window));

  assign last_level_nxt = item.sensor_level;

  always_comb begin
    for (int i = 0; i < pil_pkg::HIST_DEPTH; i++) begin
      start_nxt[i] = start_r[i];
      end_nxt[i]   = end_r[i];
    end
    if (rise && in_window) begin
      end_nxt[0] = '0;
    end else if (rise) begin
      // shift toward older entries, drop the oldest
      for (int i = 1; i < pil_pkg::HIST_DEPTH; i++) begin
        start_nxt[i] = start_r[i-1];
        end_nxt[i]   = end_r[i-1];
      end
      start_nxt[0] = item.now_seconds;
      end_nxt[0]   = '0;
    end else if (fall) begin
      end_nxt[0] = item.now_seconds;
    end
  end

  always_comb begin
    res.active     = item.sensor_level;
    res.edge_seen  = rise ? pil_pkg::EDGE_RISING :
                     fall ? pil_pkg::EDGE_FALLING : pil_pkg::EDGE_NONE;
    res.merged     = rise & in_window;
    res.slot_start = '0;
    res.slot_end   = '0;
    // slots past the history read as zero
    for (int i = 0; i < pil_pkg::HIST_DEPTH; i++) begin
      if (32'(item.read_slot) == 32'(i)) begin
        res.slot_start = start_nxt[i];
        res.slot_end   = end_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      for (int i = 0; i < pil_pkg::HIST_DEPTH; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
    end else if (upd_en) begin
      last_level_r <= last_level_nxt;
      for (int i = 0; i < pil_pkg::HIST_DEPTH; i++) begin
        start_r[i] <= start_nxt[i];
        end_r[i]   <= end_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/presence_interval_logger_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  in_tdata: level, now, read slot
// out_     master     out_tvalid/out_tready out_tdata: level, edge, merged, start, end
// cfg_     write      cfg_wr_en            cfg_wr_data: merge window
//
// One word per cycle sustained while out_tready stays high; out_tvalid for a word
// rises once it has passed the input register and then the history update into
// the result register. Reset clears the level, the whole history and the valid
// bits, and loads a merge window of 300. A stalled output keeps one word in the
// input register, then in_tready drops until out_tready returns.

module presence_interval_logger_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [0] sensor_level, [32:1] now_seconds, [35:33] read_slot, [39:36] zero
  input  wire logic [pil_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] active, [2:1] edge_seen, [3] merged, [35:4] slot_start,
  // [67:36] slot_end, [71:68] zero
  output logic [pil_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pil_pkg::WINDOW_W-1:0]      cfg_wr_data
);

  logic [pil_pkg::WINDOW_W-1:0] window_r;
  logic                         s1_valid_r;
  pil_pkg::item_t               s1_item_r;
  logic                         out_valid_r;
  pil_pkg::res_t                out_res_r;
  pil_pkg::res_t                res;
  logic                         move_out;
  logic                         upd_en;
  logic                         in_acc;

  assign move_out  = ~out_valid_r | out_tready;
  assign upd_en    = s1_valid_r & move_out;
  assign in_tready = ~s1_valid_r | move_out;
  assign in_acc    = in_tvalid & in_tready;

  pil_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd_en       (upd_en),
    .item         (s1_item_r),
    .merge_window (window_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= pil_pkg::WINDOW_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (move_out) begin
        s1_valid_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_tdata[pil_pkg::ITEM_W-1:0];
    end
    if (upd_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(pil_pkg::OUT_TDATA_W - pil_pkg::RES_W)'(0), out_res_r};

endmodule

`default_nettype wire

/* rtl/pil_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pil_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [pil_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // merge happens only on a rising edge
  a_merge_rise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2:1] == pil_pkg::EDGE_RISING)
    else $error("merged without rising edge");

  // edge kind agrees with the new level
  a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] != pil_pkg::EDGE_NONE |->
      (out_tdata[0] == (out_tdata[2:1] == pil_pkg::EDGE_RISING)) &&
      (out_tdata[2:1] == pil_pkg::EDGE_RISING ||
       out_tdata[2:1] == pil_pkg::EDGE_FALLING))
    else $error("edge code disagrees with level");

  // a full output with no take cannot leave room for a second stalled word
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tvalid && in_tready |=> !in_tready || out_tready)
    else $error("input taken beyond buffer depth");

endmodule

bind presence_interval_logger_unit pil_checker u_pil_checker (.*);

`default_nettype wire
